>>> rtl/dual_random_loop_shift_sequencer_macros.svh
// assertion macros shared by the sequencer rtl
`ifndef DUAL_RANDOM_LOOP_SHIFT_SEQUENCER_MACROS_SVH
`define DUAL_RANDOM_LOOP_SHIFT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define DRLSS_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRLSS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/drlss_pkg.sv
// shared types and constants of the dual random loop shift sequencer
`default_nettype none

package drlss_pkg;

	localparam int OUT_W      = 14;
	localparam int NOTE_W     = 7;
	localparam int RAND_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DIV_NUM_W = 20;
	localparam int DIV_Q_W   = 13;
	localparam int DIV_DEN_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_PERCENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_SPAN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_A       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_B       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEW_FACTOR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_HOLD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 3'd7;

	localparam logic [2:0] MODE_MOD1     = 3'd0;
	localparam logic [2:0] MODE_MOD2     = 3'd1;
	localparam logic [2:0] MODE_TRIG1    = 3'd2;
	localparam logic [2:0] MODE_TRIG2    = 3'd3;
	localparam logic [2:0] MODE_GATE1    = 3'd4;
	localparam logic [2:0] MODE_GATE2    = 3'd5;
	localparam logic [2:0] MODE_GATE_SUM = 3'd6;

	localparam logic [5:0]  LOOP_LENGTH_RST  = 6'd16;
	localparam logic [6:0]  FLIP_PERCENT_RST = 7'd0;
	localparam logic [5:0]  NOTE_SPAN_RST    = 6'd24;
	localparam logic [2:0]  MODE_A_RST       = MODE_GATE1;
	localparam logic [2:0]  MODE_B_RST       = MODE_TRIG2;
	localparam logic [7:0]  SLEW_FACTOR_RST  = 8'd4;
	localparam logic [15:0] TRIGGER_HOLD_RST = 16'd100;
	localparam logic [15:0] SEED_RST         = 16'd23130;

	typedef struct packed {
		logic start;
		logic neg;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

>>> rtl/drlss_if.sv
// handshake channels of the sequencer: tick items, result items, register writes
`default_nettype none

interface drlss_in_if;
	logic                             valid;
	logic                             ready;
	logic                             clock_edge;
	logic                             flip_enable;
	logic [drlss_pkg::RAND_W-1:0]     rand_a;
	logic [drlss_pkg::RAND_W-1:0]     rand_b;
	logic                             reload;

	modport source (output valid, clock_edge, flip_enable, rand_a, rand_b, reload,
		input ready);
	modport sink (input valid, clock_edge, flip_enable, rand_a, rand_b, reload,
		output ready);
endinterface

interface drlss_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [drlss_pkg::OUT_W-1:0] out_a;
	logic signed [drlss_pkg::OUT_W-1:0] out_b;
	logic [drlss_pkg::NOTE_W-1:0]       note_a;
	logic [drlss_pkg::NOTE_W-1:0]       note_b;
	logic                               bit_a;
	logic                               bit_b;

	modport source (output valid, out_a, out_b, note_a, note_b, bit_a, bit_b,
		input ready);
	modport sink (input valid, out_a, out_b, note_a, note_b, bit_a, bit_b,
		output ready);
endinterface

interface drlss_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [drlss_pkg::CFG_IDX_W-1:0]   index;
	logic [drlss_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/drlss_div.sv
// iterative signed divider for the slew update, one quotient bit per cycle
`default_nettype none

`include "dual_random_loop_shift_sequencer_macros.svh"

module drlss_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  drlss_pkg::div_ctl_t                   ctl,
	input  logic [drlss_pkg::DIV_NUM_W-1:0]       num,
	input  logic [drlss_pkg::DIV_DEN_W-1:0]       den,
	output drlss_pkg::div_stat_t                  stat,
	output logic signed [drlss_pkg::OUT_W-1:0]    quo
);

	localparam int NUM_W = drlss_pkg::DIV_NUM_W;
	localparam int Q_W   = drlss_pkg::DIV_Q_W;
	localparam int DEN_W = drlss_pkg::DIV_DEN_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   qsh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, qsh_q[Q_W-1]};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	end

	// the quotient fits in Q_W bits, so the top numerator bits start as remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				rem_q  <= DEN_W'(num[NUM_W-1:Q_W]);
				qsh_q  <= num[Q_W-1:0];
				den_q  <= den;
				neg_q  <= ctl.neg;
				cnt_q  <= CNT_W'(Q_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_next;
				qsh_q <= {qsh_q[Q_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = neg_q ? -$signed({1'b0, qsh_q}) : $signed({1'b0, qsh_q});

	`DRLSS_ASSERT_IMP(a_start_when_free, clk, arst_n, ctl.start, !busy_q, "divider started while busy")
	`DRLSS_ASSERT_NEXT(a_done_ends_busy, clk, arst_n, done_q, !busy_q || ctl.start, "divider busy after done")

endmodule

`default_nettype wire

>>> rtl/dual_random_loop_shift_sequencer.sv
// top level of the dual random loop shift sequencer
//
// channel  role    handshake        payload
// tick     sink    valid / ready    clock_edge, flip_enable, rand_a, rand_b, reload
// res      source  valid / ready    out_a, out_b, note_a, note_b, bit_a, bit_b
// cfg      sink    valid / ready=1  index, data
//
// after acceptance an item passes through derive and a channel step for each
// channel, plus, for each channel that slews this tick, a sum, the divider and write back;
// the shared divider serves both channels in turn; ready is high only while idle
// reset loads registers A and B from the seed and its complement, clears
// held outputs, trigger timers and slew phase
// a result waits in the output register; a stalled sink holds the next
// item in its done state until the register frees
`default_nettype none

`include "dual_random_loop_shift_sequencer_macros.svh"

module dual_random_loop_shift_sequencer #(
	parameter int FULL_SCALE = 7680,
	parameter int REG_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	drlss_in_if.sink    tick,
	drlss_out_if.source res,
	drlss_cfg_if.sink   cfg
);

	localparam int OUT_W  = drlss_pkg::OUT_W;
	localparam int NOTE_W = drlss_pkg::NOTE_W;
	localparam int IDX_W  = $clog2(REG_BITS);
	localparam int MAX_LEN = (REG_BITS < 32) ? REG_BITS : 32;

	localparam logic [5:0]          MAX_LEN_C = 6'(MAX_LEN);
	localparam logic [63:0]         SEED_RST64 = 64'(drlss_pkg::SEED_RST);
	localparam logic [REG_BITS-1:0] SR_A_RST = SEED_RST64[REG_BITS-1:0];
	localparam logic [REG_BITS-1:0] SR_B_RST = ~SR_A_RST;
	localparam logic signed [OUT_W-1:0] FS      = OUT_W'(FULL_SCALE);
	localparam logic signed [OUT_W-1:0] FS_HALF = OUT_W'(FULL_SCALE / 2);
	localparam logic signed [14:0]      FS_W    = 15'(FULL_SCALE);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DERIVE,
		S_CH,
		S_SUM,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	// registers
	logic [5:0]  loop_len_q;
	logic [6:0]  flip_pct_q;
	logic [5:0]  span_q;
	logic [2:0]  mode_a_q;
	logic [2:0]  mode_b_q;
	logic [7:0]  slew_q;
	logic [15:0] hold_q;
	logic [15:0] seed_q;

	logic [REG_BITS-1:0]       sr_q [2];
	logic signed [OUT_W-1:0]   held_q [2];
	logic signed [16:0]        tmr_q [2];
	logic [6:0]                phase_q;
	logic                      ch_q;
	logic                      clk_q;
	logic signed [OUT_W-1:0]   mod_q [2];
	logic [NOTE_W-1:0]         note_q [2];
	logic signed [21:0]        prod_q;
	logic signed [OUT_W-1:0]   tgt_q;

	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   out_a_q;
	logic signed [OUT_W-1:0]   out_b_q;
	logic [NOTE_W-1:0]         note_a_q;
	logic [NOTE_W-1:0]         note_b_q;
	logic                      bit_a_q;
	logic                      bit_b_q;

	// clamped settings
	logic [5:0]          len_c;
	logic [5:0]          len_m1;
	logic [IDX_W-1:0]    tap_idx;
	logic [6:0]          prob_c;
	logic [5:0]          span_c;
	logic [7:0]          s_c;
	logic [6:0]          s_m1;
	logic                slew_on;
	logic [63:0]         seed64;
	logic [REG_BITS-1:0] seed_ext;
	logic [REG_BITS-1:0] sr_next [2];
	logic                flip [2];
	logic                last [2];

	always_comb begin
		priority if (loop_len_q < 6'd2) len_c = 6'd2;
		else if (loop_len_q > MAX_LEN_C) len_c = MAX_LEN_C;
		else len_c = loop_len_q;
		len_m1  = len_c - 6'd1;
		tap_idx = len_m1[IDX_W-1:0];

		if (!tick.flip_enable) prob_c = 7'd0;
		else if (flip_pct_q > 7'd100) prob_c = 7'd100;
		else prob_c = flip_pct_q;

		priority if (span_q == 6'd0) span_c = 6'd1;
		else if (span_q > 6'd32) span_c = 6'd32;
		else span_c = span_q;

		priority if (slew_q == 8'd0) s_c = 8'd1;
		else if (slew_q > 8'd128) s_c = 8'd128;
		else s_c = slew_q;
		s_m1    = 7'(s_c - 8'd1);
		slew_on = phase_q == 7'd0;

		seed64   = 64'(seed_q);
		seed_ext = seed64[REG_BITS-1:0];

		flip[0] = tick.rand_a < prob_c;
		flip[1] = tick.rand_b < prob_c;
		for (int i = 0; i < 2; i++) begin
			last[i] = sr_q[i][tap_idx] ^ flip[i];
			if (tick.reload) sr_next[i] = (i == 0) ? seed_ext : ~seed_ext;
			else if (tick.clock_edge) sr_next[i] = {sr_q[i][REG_BITS-2:0], last[i]};
			else sr_next[i] = sr_q[i];
		end
	end

	// notes and modulation from the low byte
	logic [7:0]              lo [2];
	logic [13:0]             nx [2];
	logic [4:0]              nq [2];
	logic [8:0]              nr [2];
	logic [NOTE_W-1:0]       note_c [2];
	logic signed [8:0]       md [2];
	logic signed [23:0]      mp [2];
	logic signed [23:0]      mpa [2];
	logic signed [OUT_W-1:0] mod_c [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			lo[i]     = sr_q[i][7:0];
			nx[i]     = 14'(lo[i]) * 14'(span_c);
			nq[i]     = nx[i][12:8];
			nr[i]     = {1'b0, nx[i][7:0]} + 9'(nq[i]);
			note_c[i] = 7'd64 + 7'(nq[i]) + 7'(nr[i] >= 9'd255);
			md[i]     = $signed({1'b0, lo[i]}) - 9'sd127;
			mp[i]     = md[i] * FS_W;
			mpa[i]    = mp[i][23] ? mp[i] + 24'sd127 : mp[i];
			mod_c[i]  = OUT_W'(mpa[i] >>> 7);
		end
	end

	// per-channel decode
	logic [2:0]              ch_mode;
	logic                    sel_bit;
	logic signed [OUT_W-1:0] held_c;
	logic signed [16:0]      tmr_c;
	logic signed [16:0]      tmr_dec;
	logic signed [16:0]      tmr_new;
	logic                    fire;
	logic                    want;
	logic signed [OUT_W-1:0] tgt_c;
	logic signed [21:0]      prod_c;
	logic signed [21:0]      sum_c;
	logic signed [21:0]      mag_c;

	always_comb begin
		ch_mode = ch_q ? mode_b_q : mode_a_q;
		sel_bit = sr_q[ch_mode[0]][0];
		held_c  = held_q[ch_q];
		tmr_c   = tmr_q[ch_q];
		tmr_dec = tmr_c[16] ? tmr_c : tmr_c - 17'sd1;
		tmr_new = tmr_c;
		fire    = 1'b0;
		want    = 1'b0;
		tgt_c   = '0;
		unique case (ch_mode)
			drlss_pkg::MODE_MOD1, drlss_pkg::MODE_MOD2: begin
				want  = 1'b1;
				tgt_c = mod_q[ch_mode[0]];
			end
			drlss_pkg::MODE_TRIG1, drlss_pkg::MODE_TRIG2: begin
				if (clk_q && sel_bit) begin
					fire    = 1'b1;
					tmr_new = $signed({1'b0, hold_q});
				end else begin
					tmr_new = tmr_dec;
					want    = tmr_dec[16];
				end
			end
			drlss_pkg::MODE_GATE1, drlss_pkg::MODE_GATE2: begin
				want  = 1'b1;
				tgt_c = sel_bit ? FS : '0;
			end
			drlss_pkg::MODE_GATE_SUM: begin
				want = 1'b1;
				priority if (sr_q[0][0] && sr_q[1][0]) tgt_c = FS;
				else if (sr_q[0][0] || sr_q[1][0]) tgt_c = FS_HALF;
				else tgt_c = '0;
			end
			default: begin
			end
		endcase
		prod_c = held_c * $signed({1'b0, s_m1});
		sum_c  = prod_q + tgt_q;
		mag_c  = sum_c[21] ? -sum_c : sum_c;
	end

	drlss_pkg::div_ctl_t                  div_ctl;
	drlss_pkg::div_stat_t                 div_stat;
	logic signed [OUT_W-1:0]              div_quo;

	assign div_ctl.start = state_q == S_SUM;
	assign div_ctl.neg   = sum_c[21];

	drlss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (mag_c[drlss_pkg::DIV_NUM_W-1:0]),
		.den    (s_c),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_len_q <= drlss_pkg::LOOP_LENGTH_RST;
			flip_pct_q <= drlss_pkg::FLIP_PERCENT_RST;
			span_q     <= drlss_pkg::NOTE_SPAN_RST;
			mode_a_q   <= drlss_pkg::MODE_A_RST;
			mode_b_q   <= drlss_pkg::MODE_B_RST;
			slew_q     <= drlss_pkg::SLEW_FACTOR_RST;
			hold_q     <= drlss_pkg::TRIGGER_HOLD_RST;
			seed_q     <= drlss_pkg::SEED_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				drlss_pkg::CFG_LOOP_LENGTH:  loop_len_q <= cfg.data[5:0];
				drlss_pkg::CFG_FLIP_PERCENT: flip_pct_q <= cfg.data[6:0];
				drlss_pkg::CFG_NOTE_SPAN:    span_q     <= cfg.data[5:0];
				drlss_pkg::CFG_MODE_A:       mode_a_q   <= cfg.data[2:0];
				drlss_pkg::CFG_MODE_B:       mode_b_q   <= cfg.data[2:0];
				drlss_pkg::CFG_SLEW_FACTOR:  slew_q     <= cfg.data[7:0];
				drlss_pkg::CFG_TRIGGER_HOLD: hold_q     <= cfg.data;
				drlss_pkg::CFG_SEED:         seed_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= 1'b0;
			clk_q       <= 1'b0;
			sr_q[0]     <= SR_A_RST;
			sr_q[1]     <= SR_B_RST;
			held_q[0]   <= '0;
			held_q[1]   <= '0;
			tmr_q[0]    <= '0;
			tmr_q[1]    <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || res.ready)) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						sr_q[0] <= sr_next[0];
						sr_q[1] <= sr_next[1];
						clk_q   <= tick.clock_edge;
						state_q <= S_DERIVE;
					end
				end
				S_DERIVE: begin
					mod_q[0]  <= mod_c[0];
					mod_q[1]  <= mod_c[1];
					note_q[0] <= note_c[0];
					note_q[1] <= note_c[1];
					ch_q      <= 1'b0;
					state_q   <= S_CH;
				end
				S_CH: begin
					if (fire) held_q[ch_q] <= FS;
					tmr_q[ch_q] <= tmr_new;
					if (want && slew_on) begin
						prod_q  <= prod_c;
						tgt_q   <= tgt_c;
						state_q <= S_SUM;
					end else if (ch_q) begin
						state_q <= S_DONE;
					end else begin
						ch_q <= 1'b1;
					end
				end
				S_SUM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						held_q[ch_q] <= div_quo;
						if (ch_q) begin
							state_q <= S_DONE;
						end else begin
							ch_q    <= 1'b1;
							state_q <= S_CH;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_a_q     <= held_q[0];
						out_b_q     <= held_q[1];
						note_a_q    <= note_q[0];
						note_b_q    <= note_q[1];
						bit_a_q     <= sr_q[0][0];
						bit_b_q     <= sr_q[1][0];
						if ({1'b0, phase_q} + 8'd1 >= s_c) phase_q <= '0;
						else phase_q <= phase_q + 7'd1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tick.ready = state_q == S_IDLE;
	assign cfg.ready  = 1'b1;
	assign res.valid  = out_valid_q;
	assign res.out_a  = out_a_q;
	assign res.out_b  = out_b_q;
	assign res.note_a = note_a_q;
	assign res.note_b = note_b_q;
	assign res.bit_a  = bit_a_q;
	assign res.bit_b  = bit_b_q;

	`DRLSS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, tick.valid && tick.ready, !tick.ready, "ready after item accepted")
	`DRLSS_ASSERT_IMP(a_done_in_div, clk, arst_n, div_stat.done, state_q == S_DIV, "divider done outside wait state")
	`DRLSS_ASSERT_IMP(a_timer_floor, clk, arst_n, 1'b1, (!tmr_q[0][16] || (&tmr_q[0])) && (!tmr_q[1][16] || (&tmr_q[1])), "trigger timer below -1")
	`DRLSS_ASSERT_NEXT(a_result_load, clk, arst_n, state_q == S_DONE && !out_valid_q, out_valid_q && state_q == S_IDLE, "result not loaded")

endmodule

`default_nettype wire

>>> tb/dual_random_loop_shift_sequencer_tb.sv
// self-checking testbench of the dual random loop shift sequencer: directed and random ticks
`timescale 1ns / 1ps

module dual_random_loop_shift_sequencer_tb;

	localparam int FULL_SCALE = 7680;
	localparam int REG_BITS = 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEGMENTS = 6;
	localparam int TICKS_PER_SEGMENT = 63;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	typedef struct packed {
		logic                         clock_edge;
		logic                         flip_enable;
		logic [drlss_pkg::RAND_W-1:0] rand_a;
		logic [drlss_pkg::RAND_W-1:0] rand_b;
		logic                         reload;
	} tick_t;

	typedef struct packed {
		logic [drlss_pkg::OUT_W-1:0]  out_a;
		logic [drlss_pkg::OUT_W-1:0]  out_b;
		logic [drlss_pkg::NOTE_W-1:0] note_a;
		logic [drlss_pkg::NOTE_W-1:0] note_b;
		logic                         bit_a;
		logic                         bit_b;
	} result_t;

	class tick_scoreboard;
		logic [5:0]          loop_len;
		logic [6:0]          flip_pct;
		logic [5:0]          span_reg;
		logic [2:0]          modes[2];
		logic [7:0]          slew_reg;
		logic [15:0]         hold_reg;
		logic [15:0]         seed_reg;
		logic [REG_BITS-1:0] loop_regs[2];
		int                  held[2];
		int                  timer[2];
		int                  slew_count;
		result_t             expected_results[$];
		int                  ticks_seen;
		int                  results_checked;
		int                  errors;

		function new();
			loop_len = drlss_pkg::LOOP_LENGTH_RST;
			flip_pct = drlss_pkg::FLIP_PERCENT_RST;
			span_reg = drlss_pkg::NOTE_SPAN_RST;
			modes[0] = drlss_pkg::MODE_A_RST;
			modes[1] = drlss_pkg::MODE_B_RST;
			slew_reg = drlss_pkg::SLEW_FACTOR_RST;
			hold_reg = drlss_pkg::TRIGGER_HOLD_RST;
			seed_reg = drlss_pkg::SEED_RST;
			reload_regs();
			held[0] = 0;
			held[1] = 0;
			timer[0] = 0;
			timer[1] = 0;
			slew_count = 0;
			ticks_seen = 0;
			results_checked = 0;
			errors = 0;
		endfunction

		function void reload_regs();
			loop_regs[0] = REG_BITS'(seed_reg);
			loop_regs[1] = ~REG_BITS'(seed_reg);
		endfunction

		function int clip(int v, int lo, int hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int slewed(int prev, int target, bit active, int s);
			if (!active)
				return prev;
			return (prev * (s - 1) + target) / s;
		endfunction

		function void note_reg_write(logic [drlss_pkg::CFG_IDX_W-1:0] idx,
				logic [drlss_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				drlss_pkg::CFG_LOOP_LENGTH:  loop_len = data[5:0];
				drlss_pkg::CFG_FLIP_PERCENT: flip_pct = data[6:0];
				drlss_pkg::CFG_NOTE_SPAN:    span_reg = data[5:0];
				drlss_pkg::CFG_MODE_A:       modes[0] = data[2:0];
				drlss_pkg::CFG_MODE_B:       modes[1] = data[2:0];
				drlss_pkg::CFG_SLEW_FACTOR:  slew_reg = data[7:0];
				drlss_pkg::CFG_TRIGGER_HOLD: hold_reg = data[15:0];
				drlss_pkg::CFG_SEED:         seed_reg = data[15:0];
				default: ;
			endcase
		endfunction

		function void note_tick(tick_t t);
			int         len;
			int         prob;
			int         span;
			int         s;
			int         lo;
			int         o;
			int         i;
			bit         active;
			logic       last;
			logic [2:0] m;
			int         rnd[2];
			logic       bits[2];
			int         notes[2];
			int         mods[2];
			result_t    e;

			len = clip(int'(loop_len), 2, 32);
			prob = t.flip_enable ? clip(int'(flip_pct), 0, 100) : 0;
			span = clip(int'(span_reg), 1, 32);
			s = clip(int'(slew_reg), 1, 128);
			active = (slew_count == 0);
			rnd[0] = int'(t.rand_a);
			rnd[1] = int'(t.rand_b);

			if (t.reload) begin
				reload_regs();
			end else if (t.clock_edge) begin
				for (i = 0; i < 2; i++) begin
					last = loop_regs[i][len-1];
					if (rnd[i] < prob)
						last = ~last;
					loop_regs[i] = {loop_regs[i][REG_BITS-2:0], last};
				end
			end

			for (i = 0; i < 2; i++) begin
				lo = int'(loop_regs[i][7:0]);
				bits[i] = loop_regs[i][0];
				notes[i] = lo * span / 255 + 64;
				mods[i] = (lo - 127) * FULL_SCALE / 128;
			end

			for (i = 0; i < 2; i++) begin
				m = modes[i];
				o = held[i];
				case (m)
					drlss_pkg::MODE_MOD1, drlss_pkg::MODE_MOD2: begin
						o = slewed(o, mods[m == drlss_pkg::MODE_MOD2], active, s);
					end
					drlss_pkg::MODE_TRIG1, drlss_pkg::MODE_TRIG2: begin
						if (t.clock_edge && bits[m == drlss_pkg::MODE_TRIG2]) begin
							o = FULL_SCALE;
							timer[i] = int'(hold_reg);
						end else begin
							if (timer[i] > -1)
								timer[i]--;
							if (timer[i] < 0)
								o = slewed(o, 0, active, s);
						end
					end
					drlss_pkg::MODE_GATE1, drlss_pkg::MODE_GATE2: begin
						o = slewed(o, bits[m == drlss_pkg::MODE_GATE2] ? FULL_SCALE : 0,
							active, s);
					end
					drlss_pkg::MODE_GATE_SUM: begin
						o = slewed(o, (int'(bits[0]) + int'(bits[1])) * FULL_SCALE / 2,
							active, s);
					end
					default: ;
				endcase
				held[i] = o;
			end

			if (slew_count + 1 >= s)
				slew_count = 0;
			else
				slew_count++;

			e.out_a = held[0][drlss_pkg::OUT_W-1:0];
			e.out_b = held[1][drlss_pkg::OUT_W-1:0];
			e.note_a = notes[0][drlss_pkg::NOTE_W-1:0];
			e.note_b = notes[1][drlss_pkg::NOTE_W-1:0];
			e.bit_a = bits[0];
			e.bit_b = bits[1];
			expected_results.push_back(e);
			ticks_seen++;
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result item with no tick waiting: expected none, actual out_a=%0d out_b=%0d",
					$time, $signed(r.out_a), $signed(r.out_b));
				return;
			end
			e = expected_results.pop_front();
			results_checked++;
			compare_field("out_a", $signed(e.out_a), $signed(r.out_a));
			compare_field("out_b", $signed(e.out_b), $signed(r.out_b));
			compare_field("note_a", {25'd0, e.note_a}, {25'd0, r.note_a});
			compare_field("note_b", {25'd0, e.note_b}, {25'd0, r.note_b});
			compare_field("bit_a", {31'd0, e.bit_a}, {31'd0, r.bit_a});
			compare_field("bit_b", {31'd0, e.bit_b}, {31'd0, r.bit_b});
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle;
	int   rx_idle;
	int   cycles = 0;
	int   settings_applied;

	tick_scoreboard sb;

	drlss_in_if  tick_ch();
	drlss_out_if res_ch();
	drlss_cfg_if cfg_ch();

	dual_random_loop_shift_sequencer #(
		.FULL_SCALE(FULL_SCALE),
		.REG_BITS(REG_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(result_t'({res_ch.out_a, res_ch.out_b, res_ch.note_a,
					res_ch.note_b, res_ch.bit_a, res_ch.bit_b}));
			if (tick_ch.valid && tick_ch.ready)
				sb.note_tick(tick_t'({tick_ch.clock_edge, tick_ch.flip_enable,
					tick_ch.rand_a, tick_ch.rand_b, tick_ch.reload}));
			if (cfg_ch.valid && cfg_ch.ready)
				sb.note_reg_write(cfg_ch.index, cfg_ch.data);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results outstanding", $time, sb.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_tick(input logic ce, input logic fe,
			input logic [drlss_pkg::RAND_W-1:0] ra, input logic [drlss_pkg::RAND_W-1:0] rb,
			input logic rl);
		while ($urandom_range(99) < tx_idle) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.clock_edge <= ce;
		tick_ch.flip_enable <= fe;
		tick_ch.rand_a <= ra;
		tick_ch.rand_b <= rb;
		tick_ch.reload <= rl;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_random_tick();
		logic                         ce;
		logic                         fe;
		logic                         rl;
		logic [drlss_pkg::RAND_W-1:0] ra;
		logic [drlss_pkg::RAND_W-1:0] rb;
		ce = ($urandom_range(99) < 65);
		fe = ($urandom_range(3) != 0);
		rl = ($urandom_range(39) == 0);
		if ($urandom_range(9) == 0)
			ra = $urandom_range(127, 100);
		else
			ra = $urandom_range(99);
		if ($urandom_range(9) == 0)
			rb = $urandom_range(127, 100);
		else
			rb = $urandom_range(99);
		send_tick(ce, fe, ra, rb, rl);
	endtask

	// hold off the sender until every result item is back
	task automatic wait_quiet();
		tick_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
	endtask

	task automatic cfg_write(input logic [drlss_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= drlss_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic apply_regs(input int loop_len, input int flip, input int span,
			input int mode_a, input int mode_b, input int slew, input int hold, input int seed);
		wait_quiet();
		cfg_write(drlss_pkg::CFG_LOOP_LENGTH, loop_len);
		cfg_write(drlss_pkg::CFG_FLIP_PERCENT, flip);
		cfg_write(drlss_pkg::CFG_NOTE_SPAN, span);
		cfg_write(drlss_pkg::CFG_MODE_A, mode_a);
		cfg_write(drlss_pkg::CFG_MODE_B, mode_b);
		cfg_write(drlss_pkg::CFG_SLEW_FACTOR, slew);
		cfg_write(drlss_pkg::CFG_TRIGGER_HOLD, hold);
		cfg_write(drlss_pkg::CFG_SEED, seed);
		cfg_ch.valid <= 1'b0;
		settings_applied++;
	endtask

	// mostly in range, sometimes an end point or any 16-bit word
	function automatic int pick_value(int lo, int hi);
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		if (r == 2)
			return $urandom_range(65535);
		return $urandom_range(hi, lo);
	endfunction

	task automatic randomize_regs();
		int hold;
		if ($urandom_range(4) == 0)
			hold = pick_value(0, 65535);
		else
			hold = $urandom_range(40);
		apply_regs(pick_value(2, 32), pick_value(0, 100), pick_value(1, 32), pick_value(0, 7),
			pick_value(0, 7), pick_value(1, 128), hold, $urandom_range(65535));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		settings_applied = 0;
		tx_idle = 0;
		rx_idle = 0;
		tick_ch.valid = 1'b0;
		tick_ch.clock_edge = 1'b0;
		tick_ch.flip_enable = 1'b0;
		tick_ch.rand_a = '0;
		tick_ch.rand_b = '0;
		tick_ch.reload = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: gate one on A, trigger two on B
		send_tick(1'b1, 1'b1, 7'd0, 7'd0, 1'b0);
		send_tick(1'b0, 1'b0, 7'd127, 7'd127, 1'b0);
		send_tick(1'b1, 1'b0, 7'd99, 7'd99, 1'b0);
		send_tick(1'b1, 1'b1, 7'd0, 7'd0, 1'b1);

		// shortest loop, certain flips, no smoothing
		apply_regs(2, 100, 32, drlss_pkg::MODE_MOD1, drlss_pkg::MODE_MOD2, 1, 0, 16'hffff);
		send_tick(1'b1, 1'b1, 7'd0, 7'd0, 1'b1);
		send_tick(1'b1, 1'b1, 7'd99, 7'd100, 1'b0);
		send_tick(1'b1, 1'b1, 7'd127, 7'd0, 1'b0);
		send_tick(1'b1, 1'b0, 7'd0, 7'd0, 1'b0);
		send_tick(1'b0, 1'b1, 7'd0, 7'd0, 1'b0);

		// registers mostly above range, span below, zero hold so the timer parks at -1
		apply_regs(63, 127, 0, drlss_pkg::MODE_TRIG1, MODE_UNUSED, 255, 0, 0);
		send_tick(1'b1, 1'b1, 7'd0, 7'd0, 1'b1);
		send_tick(1'b1, 1'b1, 7'd0, 7'd50, 1'b0);
		send_tick(1'b0, 1'b0, 7'd0, 7'd0, 1'b0);
		send_tick(1'b0, 1'b0, 7'd0, 7'd0, 1'b0);
		send_tick(1'b1, 1'b1, 7'd127, 7'd127, 1'b0);

		// registers mostly below range, span above
		apply_regs(1, 0, 63, MODE_UNUSED, drlss_pkg::MODE_TRIG2, 0, 3, 16'h8001);
		send_tick(1'b1, 1'b1, 7'd0, 7'd0, 1'b1);
		send_tick(1'b1, 1'b1, 7'd0, 7'd0, 1'b0);
		send_tick(1'b1, 1'b1, 7'd0, 7'd0, 1'b0);
		send_tick(1'b0, 1'b1, 7'd0, 7'd0, 1'b0);
		send_tick(1'b0, 1'b1, 7'd0, 7'd0, 1'b0);

		apply_regs(33, 50, 16, drlss_pkg::MODE_GATE_SUM, drlss_pkg::MODE_GATE2, 2, 65535,
			16'h00ff);
		send_tick(1'b1, 1'b1, 7'd49, 7'd50, 1'b1);
		send_tick(1'b1, 1'b1, 7'd49, 7'd50, 1'b0);
		send_tick(1'b1, 1'b1, 7'd50, 7'd49, 1'b0);
		send_tick(1'b0, 1'b0, 7'd0, 7'd0, 1'b0);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle = 20;
					rx_idle = 81;
				end
				1: begin
					tx_idle = 81;
					rx_idle = 20;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				randomize_regs();
				repeat (TICKS_PER_SEGMENT) send_random_tick();
			end
		end

		wait_quiet();
		repeat (64) @(posedge clk);
		$display("%0d tick items and %0d result items checked over %0d register settings,",
			sb.ticks_seen, sb.results_checked, settings_applied);
		$display("all channel modes, reloads and clamped registers, under three idle patterns");
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
